[src/dbd_pkg.sv]
package dbd_pkg;

	// field and register widths
	localparam int DEPTH_W = 16;
	localparam int DIM_W   = 12;
	localparam int SCALE_W = 4;
	localparam int Y_W     = 11;
	localparam int SUM_W   = 22;
	localparam int CNT_W   = 7;
	localparam int MAX_HEIGHT = 2048;

	// median candidates: two stored rows plus the last row of a 3x3 block
	localparam int MED_ROWS = 6;
	localparam int MED_N    = 9;

	// register indexes
	localparam logic [1:0] CFG_SCALE  = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RECALC,
		ST_RECALC_WAIT,
		ST_MEAN_RD,
		ST_MEAN_DIV,
		ST_MED_RD,
		ST_MED_WAIT,
		ST_MED_SEL,
		ST_OUT
	} dbd_state_t;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend;
		logic [CNT_W-1:0]   divisor;
	} dbd_div_req_t;

	typedef struct packed {
		logic               done;
		logic [SUM_W-1:0]   quotient;
		logic [CNT_W-1:0]   remainder;
	} dbd_div_rsp_t;

endpackage

[src/dbd_ram.sv]
module dbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/dbd_div.sv]
module dbd_div
	import dbd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  dbd_div_req_t req,
	output dbd_div_rsp_t rsp
);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   shifted;
	logic [CNT_W+1:0] diff;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[src/depth_block_decimator.sv]
// a block word leaves after its input word is taken: median blocks pass row reads and a rank
// select, mean blocks a column update and a divide, skipped for no nonzero pixel; output stalls add.
// throughput: one word per cycle for median words that close no block; a mean word that closes
// no block holds the input for its column update; the input stalls while a block result is computed.
// reset clears position, control and output valid; memories are not cleared. after reset
// and every register write the input stalls while the position and frame size are redivided.
module depth_block_decimator
	import dbd_pkg::*;
#(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DEPTH_W-1:0] depth_in,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DEPTH_W-1:0] depth_out,
	output logic               row_end,
	output logic               frame_end
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
	localparam int SW  = $clog2(MAX_SCALE);
	localparam int SCW = SW + 1;

	dbd_state_t st_q, st_d;

	// registers
	logic [SCALE_W-1:0] scale_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic               dirty_q;

	// position
	logic [XW-1:0]  x_q, bx_q;
	logic [SW-1:0]  rx_q, ry_q;
	logic [Y_W-1:0] y_q, by_q;
	logic [XW:0]    wq_q;
	logic [DIM_W-1:0] hq_q;
	logic [1:0]     op_q;

	// item under work
	logic [DEPTH_W-1:0] d_q;
	logic [XW-1:0]      cur_x_q, cur_bx_q;
	logic               blk_done_q, clr_q, re_q, fe_q;
	logic [DEPTH_W-1:0] res_q;
	logic [CNT_W-1:0]   cnt_q;

	// median gather and select
	logic [DEPTH_W-1:0] lr_q [MAX_SCALE];
	logic [DEPTH_W-1:0] rv_q [MED_ROWS];
	logic               med_r_q;
	logic [1:0]         med_c_q;
	logic [2:0]         slot_q;
	logic               rd_v_s1;
	logic [2:0]         rd_slot_s1;
	logic [3:0]         cand_q;

	// output register
	logic               ovalid_q;
	logic [DEPTH_W-1:0] odepth_q;
	logic               orow_q, oframe_q;

	// clamped registers
	logic [SCW-1:0]   s_c;
	logic [WW-1:0]    fw_ext, w_full;
	logic [XW:0]      w_c;
	logic [DIM_W-1:0] h_c;
	logic             median;

	always_comb begin
		if (scale_q == '0) begin
			s_c = SCW'(1);
		end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
			s_c = SCW'(MAX_SCALE);
		end else begin
			s_c = scale_q[SCW-1:0];
		end
		fw_ext = WW'(width_q);
		if (fw_ext == '0) begin
			w_full = WW'(1);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			w_full = WW'(MAX_WIDTH);
		end else begin
			w_full = fw_ext;
		end
		w_c = w_full[XW:0];
		if (height_q == '0) begin
			h_c = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_c = DIM_W'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
		median = (s_c == SCW'(2)) || (s_c == SCW'(3));
	end

	// position of the offered word
	logic           xz, yz;
	logic [XW-1:0]  xc, bxc;
	logic [SW-1:0]  rxc, ryc;
	logic [Y_W-1:0] yc, byc;
	logic [XW:0]    xn;
	logic [DIM_W-1:0] yn;
	logic           done_c, re_c, fe_c, keep_row;
	logic           accept;

	always_comb begin
		xz  = frame_start || ({1'b0, x_q} >= w_c);
		yz  = frame_start || (DIM_W'(y_q) >= h_c);
		xc  = xz ? '0 : x_q;
		rxc = xz ? '0 : rx_q;
		bxc = xz ? '0 : bx_q;
		yc  = yz ? '0 : y_q;
		ryc = yz ? '0 : ry_q;
		byc = yz ? '0 : by_q;
		xn  = {1'b0, xc} + (XW+1)'(1);
		yn  = DIM_W'(yc) + DIM_W'(1);
		done_c   = (SCW'(rxc) == s_c - SCW'(1)) && (SCW'(ryc) == s_c - SCW'(1));
		re_c     = ({1'b0, bxc} == wq_q - (XW+1)'(1));
		fe_c     = re_c && (DIM_W'(byc) == hq_q - DIM_W'(1));
		keep_row = SCW'(ryc) < s_c - SCW'(1);
	end

	// divider
	dbd_div_req_t div_req;
	dbd_div_rsp_t div_rsp;

	dbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// row store for median blocks
	logic            row_we, row_re;
	logic [XW:0]     row_waddr, row_raddr;
	logic [DEPTH_W-1:0] row_rdata;
	logic [XW-1:0]   x0;

	assign x0        = cur_x_q - XW'(s_c - SCW'(1));
	assign row_waddr = {ryc[0], xc};
	assign row_raddr = {med_r_q, x0 + XW'(med_c_q)};

	dbd_ram #(
		.WIDTH (DEPTH_W),
		.DEPTH (2 * MAX_WIDTH)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (depth_in),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// column sums for mean blocks
	logic                    col_we, col_re;
	logic [CNT_W+SUM_W-1:0]  col_rdata;
	logic [SUM_W-1:0]        base_sum, new_sum;
	logic [CNT_W-1:0]        base_cnt, new_cnt;

	always_comb begin
		base_sum = clr_q ? '0 : col_rdata[SUM_W-1:0];
		base_cnt = clr_q ? '0 : col_rdata[CNT_W+SUM_W-1:SUM_W];
		new_sum  = (d_q != '0) ? base_sum + SUM_W'(d_q) : base_sum;
		new_cnt  = (d_q != '0) ? base_cnt + CNT_W'(1) : base_cnt;
	end

	dbd_ram #(
		.WIDTH (CNT_W + SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (cur_bx_q),
		.wdata ({new_cnt, new_sum}),
		.re    (col_re),
		.raddr (bxc),
		.rdata (col_rdata)
	);

	// median rank test for one candidate
	logic [DEPTH_W-1:0] cand [MED_N];
	logic [MED_N-1:0]   inc;
	logic [3:0]         kcnt, rank, target;
	logic [DEPTH_W-1:0] cv;
	logic [3:0]         nrow;

	always_comb begin
		nrow = (s_c == SCW'(2)) ? 4'd2 : 4'd6;
		for (int j = 0; j < MED_ROWS; j++) begin
			cand[j] = rv_q[j];
			inc[j]  = (4'(j) < nrow) && (rv_q[j] != '0);
		end
		for (int j = 0; j < 3; j++) begin
			cand[MED_ROWS+j] = lr_q[j];
			inc[MED_ROWS+j]  = (SCW'(j) < s_c) && (lr_q[j] != '0);
		end
		kcnt = '0;
		for (int j = 0; j < MED_N; j++) begin
			kcnt = kcnt + 4'(inc[j]);
		end
		target = (kcnt - 4'd1) >> 1;
		cv   = cand[cand_q];
		rank = '0;
		for (int j = 0; j < MED_N; j++) begin
			if (inc[j] && ((cand[j] < cv) || ((cand[j] == cv) && (4'(j) < cand_q)))) begin
				rank = rank + 4'd1;
			end
		end
	end

	logic med_last, out_free;
	assign med_last = (SCW'(med_r_q) == s_c - SCW'(2)) && (SCW'(med_c_q) == s_c - SCW'(1));
	assign out_free = !ovalid_q || !out_stall;
	assign accept   = (st_q == ST_IDLE) && !dirty_q && in_valid;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (dirty_q) begin
					st_d = ST_RECALC;
				end else if (in_valid) begin
					if (median) begin
						st_d = done_c ? ST_MED_RD : ST_IDLE;
					end else begin
						st_d = ST_MEAN_RD;
					end
				end
			end
			ST_RECALC:      st_d = ST_RECALC_WAIT;
			ST_RECALC_WAIT: begin
				if (div_rsp.done) begin
					st_d = (op_q == 2'd3) ? ST_IDLE : ST_RECALC;
				end
			end
			ST_MEAN_RD: begin
				if (!blk_done_q) begin
					st_d = ST_IDLE;
				end else begin
					st_d = (new_cnt == '0) ? ST_OUT : ST_MEAN_DIV;
				end
			end
			ST_MEAN_DIV: begin
				if (div_rsp.done) begin
					st_d = ST_OUT;
				end
			end
			ST_MED_RD: begin
				if (med_last) begin
					st_d = ST_MED_WAIT;
				end
			end
			ST_MED_WAIT:    st_d = ST_MED_SEL;
			ST_MED_SEL: begin
				if (cand_q == 4'(MED_N - 1)) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default:        st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall         = 1'b1;
		row_we           = 1'b0;
		row_re           = 1'b0;
		col_we           = 1'b0;
		col_re           = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = SUM_W'(x_q);
		div_req.divisor  = CNT_W'(s_c);
		unique case (st_q)
			ST_IDLE: begin
				in_stall = dirty_q;
				row_we   = accept && median && keep_row;
				col_re   = accept && !median;
			end
			ST_RECALC: begin
				div_req.start = 1'b1;
				case (op_q)
					2'd0:    div_req.dividend = SUM_W'(x_q);
					2'd1:    div_req.dividend = SUM_W'(y_q);
					2'd2:    div_req.dividend = SUM_W'(w_c);
					default: div_req.dividend = SUM_W'(h_c);
				endcase
			end
			ST_MEAN_RD: begin
				col_we           = 1'b1;
				div_req.start    = blk_done_q && (new_cnt != '0);
				div_req.dividend = new_sum;
				div_req.divisor  = new_cnt;
			end
			ST_MED_RD: begin
				row_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			scale_q  <= SCALE_W'(2);
			width_q  <= DIM_W'(1280);
			height_q <= DIM_W'(720);
			dirty_q  <= 1'b1;
			op_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			rx_q     <= '0;
			bx_q     <= '0;
			ry_q     <= '0;
			by_q     <= '0;
			ovalid_q <= 1'b0;
			rd_v_s1  <= 1'b0;
		end else begin
			st_q    <= st_d;
			rd_v_s1 <= (st_q == ST_MED_RD);

			// register writes schedule a position recompute
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cfg_valid) begin
				dirty_q <= 1'b1;
			end else if (st_q == ST_IDLE && dirty_q) begin
				dirty_q <= 1'b0;
			end

			if (st_q == ST_IDLE) begin
				op_q <= '0;
			end else if (st_q == ST_RECALC_WAIT && div_rsp.done) begin
				op_q <= op_q + 2'd1;
				case (op_q)
					2'd0: begin
						bx_q <= div_rsp.quotient[XW-1:0];
						rx_q <= div_rsp.remainder[SW-1:0];
					end
					2'd1: begin
						by_q <= div_rsp.quotient[Y_W-1:0];
						ry_q <= div_rsp.remainder[SW-1:0];
					end
					default: begin
					end
				endcase
			end

			// advance the raster position
			if (accept) begin
				if (xn >= w_c) begin
					x_q  <= '0;
					rx_q <= '0;
					bx_q <= '0;
					if (yn >= h_c) begin
						y_q  <= '0;
						ry_q <= '0;
						by_q <= '0;
					end else begin
						y_q <= yn[Y_W-1:0];
						if (SCW'(ryc) + SCW'(1) == s_c) begin
							ry_q <= '0;
							by_q <= byc + Y_W'(1);
						end else begin
							ry_q <= ryc + SW'(1);
							by_q <= byc;
						end
					end
				end else begin
					x_q <= xn[XW-1:0];
					y_q  <= yc;
					ry_q <= ryc;
					by_q <= byc;
					if (SCW'(rxc) + SCW'(1) == s_c) begin
						rx_q <= '0;
						bx_q <= bxc + XW'(1);
					end else begin
						rx_q <= rxc + SW'(1);
						bx_q <= bxc;
					end
				end
			end

			// output word register
			if (st_q == ST_OUT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_RECALC_WAIT && div_rsp.done) begin
			case (op_q)
				2'd2:    wq_q <= div_rsp.quotient[XW:0];
				2'd3:    hq_q <= div_rsp.quotient[DIM_W-1:0];
				default: begin
				end
			endcase
		end

		if (accept) begin
			d_q        <= depth_in;
			cur_x_q    <= xc;
			cur_bx_q   <= bxc;
			blk_done_q <= done_c;
			clr_q      <= (rxc == '0) && (ryc == '0);
			re_q       <= re_c;
			fe_q       <= fe_c;
			med_r_q    <= 1'b0;
			med_c_q    <= '0;
			slot_q     <= '0;
			if (median && !keep_row) begin
				lr_q[rxc] <= depth_in;
			end
		end

		// mean: update sums, result from divider
		if (st_q == ST_MEAN_RD) begin
			cnt_q <= new_cnt;
			res_q <= '0;
		end
		if (st_q == ST_MEAN_DIV && div_rsp.done) begin
			res_q <= div_rsp.quotient[DEPTH_W-1:0];
		end

		// median: walk the stored rows of the block
		if (st_q == ST_MED_RD) begin
			slot_q <= slot_q + 3'd1;
			if (SCW'(med_c_q) == s_c - SCW'(1)) begin
				med_c_q <= '0;
				med_r_q <= 1'b1;
			end else begin
				med_c_q <= med_c_q + 2'd1;
			end
		end
		rd_slot_s1 <= slot_q;
		if (rd_v_s1) begin
			rv_q[rd_slot_s1] <= row_rdata;
		end

		// median: one candidate rank test per cycle
		if (st_q == ST_MED_WAIT) begin
			cand_q <= '0;
			res_q  <= '0;
		end
		if (st_q == ST_MED_SEL) begin
			cand_q <= cand_q + 4'd1;
			if (inc[cand_q] && (rank == target)) begin
				res_q <= cv;
			end
		end

		if (st_q == ST_OUT && out_free) begin
			odepth_q <= res_q;
			orow_q   <= re_q;
			oframe_q <= fe_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign depth_out = odepth_q;
	assign row_end   = orow_q;
	assign frame_end = oframe_q;

`ifndef NO_ASSERTIONS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall)
		else $error("input taken while a word is in work");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (st_q == ST_RECALC_WAIT || st_q == ST_MEAN_DIV))
		else $error("divider result with no waiting state");

	a_rx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && !dirty_q) |-> (SCW'(rx_q) < s_c && SCW'(ry_q) < s_c))
		else $error("block offset outside block");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> ($past(st_q) == ST_OUT))
		else $error("output word loaded outside output state");

	a_sum_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MEAN_DIV) |-> (cnt_q != '0))
		else $error("mean divide with zero count");
`endif

endmodule
